/* sv/alaf_pkg.sv */
// ----------------------------------------------------------------------------
// alaf_pkg
// Shared types and constants of the four-lane affine local alignment fill.
// ----------------------------------------------------------------------------
`default_nettype none

package alaf_pkg;

    localparam int NUM_LANES     = 4;
    localparam int DEF_LANES     = 4;
    localparam int DEF_MAX_COLS  = 1024;
    localparam int DEF_ALPHABET  = 128;
    localparam int DEF_SCORE_BITS = 24;
    localparam int FIELD_BITS    = 24;
    localparam int CODE_BITS     = 7;
    localparam int CODE_STRIDE   = 128;
    localparam int TABLE_DEPTH   = CODE_STRIDE * CODE_STRIDE;
    localparam int TIDX_BITS     = 14;
    localparam int COLS_BITS     = 11;
    localparam int ADDR_BITS     = 4;

    localparam logic [ADDR_BITS-1:0] REG_GAP_OPEN   = 4'h0;
    localparam logic [ADDR_BITS-1:0] REG_GAP_EXTEND = 4'h4;
    localparam logic [ADDR_BITS-1:0] REG_COLUMNS    = 4'h8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CELL = 1'b1;

    localparam logic signed [FIELD_BITS-1:0] OUT_OF_RANGE_SCORE = -24'sd16000;

    typedef struct packed {
        logic                          operation;
        logic [TIDX_BITS-1:0]          table_index;
        logic signed [FIELD_BITS-1:0]  table_value;
        logic [4*CODE_BITS-1:0]        query_codes;
        logic [4*CODE_BITS-1:0]        ref_codes;
        logic [3:0]                    lane_in_range;
        logic                          final_cell;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] lane0_score;
        logic signed [FIELD_BITS-1:0] lane1_score;
        logic signed [FIELD_BITS-1:0] lane2_score;
        logic signed [FIELD_BITS-1:0] lane3_score;
        logic signed [FIELD_BITS-1:0] lane0_up_gap;
        logic signed [FIELD_BITS-1:0] lane1_up_gap;
        logic signed [FIELD_BITS-1:0] lane2_up_gap;
        logic signed [FIELD_BITS-1:0] lane3_up_gap;
        logic [11:0]                  direction_codes;
        logic                         is_summary;
        logic                         last;
    } out_item_t;

    // control flags moving along the cell pipeline
    typedef struct packed {
        logic first_row;
        logic row_start;
        logic final_cell;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/alaf_ram.sv */
// ----------------------------------------------------------------------------
// alaf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module alaf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/alaf_lane.sv */
// ----------------------------------------------------------------------------
// alaf_lane
// One lane of the Gotoh recurrence: E, F, D, H and direction code per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module alaf_lane #(
    parameter int SCORE_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic                         summary_clear,
    input  wire alaf_pkg::cell_ctl_t          ctl,
    input  wire logic signed [SCORE_BITS-1:0] subst,
    input  wire logic signed [SCORE_BITS-1:0] up_score,
    input  wire logic signed [SCORE_BITS-1:0] up_gap,
    input  wire logic [15:0]                  open_cost,
    input  wire logic [15:0]                  ext_cost,
    output logic signed [SCORE_BITS-1:0]      h_out,
    output logic signed [SCORE_BITS-1:0]      f_out,
    output logic [2:0]                        dir_out,
    output logic signed [SCORE_BITS-1:0]      best_out
);

    import alaf_pkg::*;

    localparam int W = SCORE_BITS + 2;
    localparam logic signed [W-1:0] HI = W'((64'sd1 <<< (SCORE_BITS - 1)) - 1);
    localparam logic signed [W-1:0] LO = -HI - W'(1);

    function automatic logic signed [SCORE_BITS-1:0] sat(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        begin
            r = (v > HI) ? HI : ((v < LO) ? LO : v);
            return r[SCORE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [SCORE_BITS-1:0] smax(
        input logic signed [SCORE_BITS-1:0] a,
        input logic signed [SCORE_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic signed [SCORE_BITS-1:0] e_reg, e_next;
    logic signed [SCORE_BITS-1:0] hl_reg;
    logic signed [SCORE_BITS-1:0] dg_reg;
    logic signed [SCORE_BITS-1:0] best_reg;

    logic signed [SCORE_BITS-1:0] e_l, h_l, d_l, upv, fpv, d, f, mde, mfz, h;
    logic signed [W-1:0] opn, ext;

    always_comb
    begin
        opn = W'($signed({1'b0, open_cost}));
        ext = W'($signed({1'b0, ext_cost}));
        e_l = ctl.row_start ? '0 : e_reg;
        h_l = ctl.row_start ? '0 : hl_reg;
        d_l = ctl.row_start ? '0 : dg_reg;
        upv = ctl.first_row ? '0 : up_score;
        fpv = ctl.first_row ? '0 : up_gap;
        e_next = smax(sat(W'(e_l) - ext), sat(W'(h_l) - opn));
        d = sat(W'(d_l) + W'(subst));
        f = smax(sat(W'(fpv) - ext), sat(W'(upv) - opn));
        mde = smax(d, e_next);
        mfz = smax(f, '0);
        h = smax(mde, mfz);
        h_out = h;
        f_out = f;
        dir_out = {d >= e_next, f >= 0, mde >= mfz};
        best_out = smax(best_reg, h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg <= '0;
            hl_reg <= '0;
            dg_reg <= '0;
            best_reg <= '0;
        end
        else if (step)
        begin
            e_reg <= e_next;
            hl_reg <= h;
            dg_reg <= upv;
            best_reg <= summary_clear ? '0 : smax(best_reg, h);
        end
    end

endmodule

`default_nettype wire

/* sv/affine_local_align_fill_4lane_unit.sv */
// ----------------------------------------------------------------------------
// affine_local_align_fill_4lane_unit
// Smith-Waterman / Gotoh matrix fill, four alignments in parallel lanes.
// ----------------------------------------------------------------------------
//  channel | signals                         | role
//  in      | in_valid in_ready in_data       | table loads and cells
//  out     | out_valid out_ready out_data    | cell results, summary
//  cfg     | psel penable pwrite paddr ...   | gap costs, row length
//
//  One item per cycle unless stalled: stage 1 reads the substitution table
//  and the row and column stores (registered RAM reads), stage 2 runs the
//  lanes and merges. A final cell emits two results and may stall the input.
//  Same-column reads one cell after a write are forwarded from stage 2.
//  Reset clears control and lane registers; memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_local_align_fill_4lane_unit #(
    parameter int LANES      = alaf_pkg::DEF_LANES,
    parameter int MAX_COLS   = alaf_pkg::DEF_MAX_COLS,
    parameter int ALPHABET   = alaf_pkg::DEF_ALPHABET,
    parameter int SCORE_BITS = alaf_pkg::DEF_SCORE_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire alaf_pkg::in_item_t          in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output alaf_pkg::out_item_t              out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [alaf_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import alaf_pkg::*;

    localparam int CB = $clog2(MAX_COLS);
    localparam int RW = LANES * SCORE_BITS;

    // ---------------- configuration
    logic [15:0] open_reg, ext_reg;
    logic [COLS_BITS-1:0] cols_reg;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 16'd160;
            ext_reg <= 16'd8;
            cols_reg <= COLS_BITS'(1024);
        end
        else if (wr)
        begin
            case (paddr)
                REG_GAP_OPEN:   open_reg <= pwdata[15:0];
                REG_GAP_EXTEND: ext_reg <= pwdata[15:0];
                REG_COLUMNS:    cols_reg <= pwdata[COLS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            REG_GAP_OPEN:   prdata = {16'd0, open_reg};
            REG_GAP_EXTEND: prdata = {16'd0, ext_reg};
            REG_COLUMNS:    prdata = {21'd0, cols_reg};
            default:        prdata = '0;
        endcase
    end

    // row limit: zero acts as one, clamp to MAX_COLS
    logic [16:0] limit;
    always_comb
    begin
        if (cols_reg == '0)
            limit = 17'd1;
        else if (17'(cols_reg) > 17'(MAX_COLS))
            limit = 17'(MAX_COLS);
        else
            limit = 17'(cols_reg);
    end

    // ---------------- output buffer (two entries, for the summary pair)
    out_item_t ob_reg [2];
    logic [1:0] ocnt_reg;
    logic       orp_reg;
    logic       push_cell, push_sum, pop;
    out_item_t  cell_item, sum_item;

    assign out_valid = ocnt_reg != 2'd0;
    assign out_data = ob_reg[orp_reg];
    assign pop = out_valid && out_ready;

    // ---------------- stage 1: accept and read stores
    logic accept, s1_valid_reg, s1_cell;
    logic [CB-1:0] col_reg;
    logic first_reg;
    logic s2_ok;

    cell_ctl_t s1_ctl_reg;
    logic [CB-1:0] s1_col_reg;
    logic [LANES-1:0] s1_oor_reg, s1_oor_next;

    // stage 2 result lands in a buffer with one free slot, two if final
    assign s2_ok = !s1_valid_reg || (
        (32'(ocnt_reg) - 32'(pop) + (s1_ctl_reg.final_cell ? 2 : 1)) <= 2);
    assign in_ready = s2_ok;
    assign accept = in_valid && in_ready;
    assign s1_cell = accept && in_data.operation == OP_CELL;

    logic wrap;
    assign wrap = (17'(col_reg) + 17'd1) >= limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            first_reg <= 1'b1;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ok)
                s1_valid_reg <= s1_cell;
            if (s1_cell)
            begin
                if (in_data.final_cell)
                begin
                    col_reg <= '0;
                    first_reg <= 1'b1;
                end
                else if (wrap)
                begin
                    col_reg <= '0;
                    first_reg <= 1'b0;
                end
                else
                    col_reg <= col_reg + CB'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_cell)
        begin
            s1_ctl_reg.first_row <= first_reg;
            s1_ctl_reg.row_start <= (col_reg == '0);
            s1_ctl_reg.final_cell <= in_data.final_cell;
            s1_col_reg <= col_reg;
            s1_oor_reg <= s1_oor_next;
        end
    end

    // substitution table, one RAM per lane
    logic signed [SCORE_BITS-1:0] subst_rd [LANES];
    logic tload;
    logic [CODE_BITS-1:0] lq, lr;
    assign lq = in_data.table_index[TIDX_BITS-1:CODE_BITS];
    assign lr = in_data.table_index[CODE_BITS-1:0];
    assign tload = accept && in_data.operation == OP_LOAD &&
                   32'(lq) < ALPHABET && 32'(lr) < ALPHABET;

    localparam logic signed [SCORE_BITS:0] SHI =
        (SCORE_BITS+1)'((64'sd1 <<< (SCORE_BITS-1)) - 1);
    logic signed [SCORE_BITS-1:0] load_val;
    always_comb
    begin
        if ((SCORE_BITS+1)'(in_data.table_value) > SHI)
            load_val = SHI[SCORE_BITS-1:0];
        else if ((SCORE_BITS+1)'(in_data.table_value) < -SHI - 1)
            load_val = SCORE_BITS'(-SHI - 1);
        else
            load_val = SCORE_BITS'(in_data.table_value);
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_tab
            logic [CODE_BITS-1:0] q, r;
            assign q = in_data.query_codes[CODE_BITS*g +: CODE_BITS];
            assign r = in_data.ref_codes[CODE_BITS*g +: CODE_BITS];
            assign s1_oor_next[g] = !in_data.lane_in_range[g] || 32'(q) >= ALPHABET ||
                                    32'(r) >= ALPHABET;
            alaf_ram #(.WIDTH(SCORE_BITS), .DEPTH(TABLE_DEPTH)) u_tab (
                .clk   (clk),
                .we    (tload),
                .waddr (in_data.table_index),
                .wdata (load_val),
                .re    (s1_cell),
                .raddr ({q, r}),
                .rdata (subst_rd[g])
            );
        end
    endgenerate

    // row and column stores
    logic [RW-1:0] row_rd, gap_rd, row_wd, gap_wd;
    logic st_we;
    alaf_ram #(.WIDTH(RW), .DEPTH(MAX_COLS)) u_row (
        .clk(clk), .we(st_we), .waddr(s1_col_reg), .wdata(row_wd),
        .re(s1_cell), .raddr(col_reg), .rdata(row_rd));
    alaf_ram #(.WIDTH(RW), .DEPTH(MAX_COLS)) u_gap (
        .clk(clk), .we(st_we), .waddr(s1_col_reg), .wdata(gap_wd),
        .re(s1_cell), .raddr(col_reg), .rdata(gap_rd));

    // forward when the cell in stage 2 writes the column just read
    logic fwd_reg;
    logic [RW-1:0] fwd_row_reg, fwd_gap_reg;
    always_ff @(posedge clk)
    begin
        if (s1_cell)
        begin
            fwd_reg <= st_we && s1_col_reg == col_reg;
            fwd_row_reg <= row_wd;
            fwd_gap_reg <= gap_wd;
        end
    end

    // ---------------- stage 2: lanes and merge
    logic step;
    assign step = s1_valid_reg && s2_ok;
    assign st_we = step;

    logic signed [SCORE_BITS-1:0] h_l [LANES];
    logic signed [SCORE_BITS-1:0] f_l [LANES];
    logic signed [SCORE_BITS-1:0] b_l [LANES];
    logic [2:0] d_l [LANES];

    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            logic signed [SCORE_BITS-1:0] sub, ups, upg;
            assign sub = s1_oor_reg[g] ? SCORE_BITS'(OUT_OF_RANGE_SCORE) : subst_rd[g];
            assign ups = fwd_reg ? fwd_row_reg[SCORE_BITS*g +: SCORE_BITS]
                                 : row_rd[SCORE_BITS*g +: SCORE_BITS];
            assign upg = fwd_reg ? fwd_gap_reg[SCORE_BITS*g +: SCORE_BITS]
                                 : gap_rd[SCORE_BITS*g +: SCORE_BITS];
            alaf_lane #(.SCORE_BITS(SCORE_BITS)) u_lane (
                .clk           (clk),
                .rst_n         (rst_n),
                .step          (step),
                .summary_clear (s1_ctl_reg.final_cell),
                .ctl           (s1_ctl_reg),
                .subst         (sub),
                .up_score      (ups),
                .up_gap        (upg),
                .open_cost     (open_reg),
                .ext_cost      (ext_reg),
                .h_out         (h_l[g]),
                .f_out         (f_l[g]),
                .dir_out       (d_l[g]),
                .best_out      (b_l[g])
            );
            assign row_wd[SCORE_BITS*g +: SCORE_BITS] = h_l[g];
            assign gap_wd[SCORE_BITS*g +: SCORE_BITS] = f_l[g];
        end
    endgenerate

    // merge lanes into result items; absent lanes read zero
    logic signed [FIELD_BITS-1:0] hx [4];
    logic signed [FIELD_BITS-1:0] fx [4];
    logic signed [FIELD_BITS-1:0] bx [4];
    logic [11:0] dx;
    always_comb
    begin
        dx = '0;
        for (int k = 0; k < 4; k++)
        begin
            hx[k] = '0;
            fx[k] = '0;
            bx[k] = '0;
            if (k < LANES)
            begin
                hx[k] = FIELD_BITS'(h_l[k]);
                fx[k] = FIELD_BITS'(f_l[k]);
                bx[k] = FIELD_BITS'(b_l[k]);
                dx[3*k +: 3] = d_l[k];
            end
        end
        cell_item = '{hx[0], hx[1], hx[2], hx[3], fx[0], fx[1], fx[2], fx[3],
                      dx, 1'b0, !s1_ctl_reg.final_cell};
        sum_item = '{bx[0], bx[1], bx[2], bx[3], '0, '0, '0, '0,
                     12'd0, 1'b1, 1'b1};
    end

    assign push_cell = step;
    assign push_sum = step && s1_ctl_reg.final_cell;

    logic [1:0] ocnt_mid;
    logic       wp;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
            orp_reg <= 1'b0;
        end
        else
        begin
            ocnt_reg <= ocnt_mid + 2'(push_cell) + 2'(push_sum);
            if (pop)
                orp_reg <= !orp_reg;
        end
    end

    assign ocnt_mid = ocnt_reg - 2'(pop);
    assign wp = orp_reg ^ ocnt_reg[0];

    always_ff @(posedge clk)
    begin
        if (push_cell)
            ob_reg[wp] <= cell_item;
        if (push_sum)
            ob_reg[!wp] <= sum_item;
    end

    // ---------------- checks
    a_ocnt: assert property (@(posedge clk) disable iff (!rst_n) ocnt_reg <= 2'd2)
        else $error("output buffer overflow");
    a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_summary |-> out_data.last)
        else $error("summary without last");
    a_final_pair: assert property (@(posedge clk) disable iff (!rst_n)
        push_sum |-> push_cell && ocnt_mid == 2'd0)
        else $error("summary pushed without room");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        17'(col_reg) < 17'(MAX_COLS))
        else $error("column position out of range");

endmodule

`default_nettype wire
